// ----- hdl/bmpu_pkg.sv -----
// ----------------------------------------------------------------------------
// bmpu_pkg
// Shared types and constants of the BMP pixel to RGBA unpacker.
// ----------------------------------------------------------------------------
package bmpu_pkg;

  localparam int DIM_W  = 13;  // width / height / counters
  localparam int PX_W   = 32;  // gathered pixel, up to four bytes
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] COLOR_KEY = 8'h01;
  localparam logic [BYTE_W-1:0] OPAQUE    = 8'hff;

  // pixel formats
  localparam logic [1:0] FMT_PAL8  = 2'd0;
  localparam logic [1:0] FMT_RGB16 = 2'd1;
  localparam logic [1:0] FMT_BGR24 = 2'd2;
  localparam logic [1:0] FMT_BGRA  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_FORMAT = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // request kinds on in_tuser
  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_PIXEL   = 1'b1;

  // completed pixel waiting for its palette read
  typedef struct packed {
    logic            valid;
    logic            last;
    logic            pal_hit;
    logic [PX_W-1:0] px;
  } pix_stage_t;

endpackage

// ----- hdl/bmpu_ram.sv -----
// ----------------------------------------------------------------------------
// bmpu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bmpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- hdl/bmpu_gather.sv -----
// ----------------------------------------------------------------------------
// bmpu_gather
// Byte gathering, row padding and column/row counting; issues the palette
// read and loads the pixel stage when a pixel completes.
// ----------------------------------------------------------------------------
module bmpu_gather
  import bmpu_pkg::*;
#(
  parameter int PAL_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,        // pixel data byte accepted
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [1:0]        fmt,
  input  logic [DIM_W-1:0]  eff_width,
  input  logic [DIM_W-1:0]  eff_height,
  input  logic              stage_ready,
  output logic              rd_en,
  output logic [BYTE_W-1:0] rd_idx,
  output pix_stage_t        stage_r
);

  logic [23:0]      gather_r, gather_nxt;
  logic [1:0]       bip_r, bip_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  pix_stage_t       stage_nxt;

  logic             completes;
  logic [PX_W-1:0]  px;
  logic             row_end;
  logic             img_end;
  logic [2:0]       bpp;
  logic [1:0]       row_bytes_lo;

  always_comb begin
    completes = (pad_r == 2'd0) && (bip_r >= fmt);
    case (bip_r)
      2'd0:    px = {24'd0, data_byte};
      2'd1:    px = {16'd0, data_byte, gather_r[7:0]};
      2'd2:    px = {8'd0, data_byte, gather_r[15:0]};
      default: px = {data_byte, gather_r};
    endcase
    row_end      = ({1'b0, col_r} + 14'd1) >= {1'b0, eff_width};
    img_end      = ({1'b0, row_r} + 14'd1) >= {1'b0, eff_height};
    bpp          = {1'b0, fmt} + 3'd1;
    row_bytes_lo = 2'(eff_width[1:0] * bpp[1:0]);
  end

  assign rd_en  = acc && completes;
  assign rd_idx = px[BYTE_W-1:0];

  always_comb begin
    gather_nxt = gather_r;
    bip_nxt    = bip_r;
    col_nxt    = col_r;
    pad_nxt    = pad_r;
    row_nxt    = row_r;
    if (acc) begin
      if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;
      end else if (!completes) begin
        case (bip_r)
          2'd0:    gather_nxt = {gather_r[23:8], data_byte};
          2'd1:    gather_nxt = {gather_r[23:16], data_byte, gather_r[7:0]};
          default: gather_nxt = {data_byte, gather_r[15:0]};
        endcase
        bip_nxt = bip_r + 2'd1;
      end else begin
        gather_nxt = 24'd0;
        bip_nxt    = 2'd0;
        if (row_end) begin
          col_nxt = '0;
          pad_nxt = 2'd0 - row_bytes_lo;  // pad up to a multiple of 4 bytes
          row_nxt = img_end ? '0 : row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    stage_nxt = stage_r;
    if (stage_ready) begin
      stage_nxt.valid   = rd_en;
      stage_nxt.last    = row_end && img_end;
      stage_nxt.pal_hit = {1'b0, px[BYTE_W-1:0]} < 9'(PAL_ENTRIES);
      stage_nxt.px      = px;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gather_r      <= '0;
      bip_r         <= '0;
      col_r         <= '0;
      pad_r         <= '0;
      row_r         <= '0;
      stage_r.valid <= 1'b0;
    end else begin
      gather_r      <= gather_nxt;
      bip_r         <= bip_nxt;
      col_r         <= col_nxt;
      pad_r         <= pad_nxt;
      row_r         <= row_nxt;
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.last    <= stage_nxt.last;
    stage_r.pal_hit <= stage_nxt.pal_hit;
    stage_r.px      <= stage_nxt.px;
  end

endmodule

// ----- hdl/bmpu_convert.sv -----
// ----------------------------------------------------------------------------
// bmpu_convert
// Format conversion to RGBA8888 and the output register.
// ----------------------------------------------------------------------------
module bmpu_convert
  import bmpu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  pix_stage_t        stage,
  input  logic [PX_W-1:0]   pal_word,
  input  logic [1:0]        fmt,
  input  logic              out_ready,
  output logic              out_valid_r,
  output logic [BYTE_W-1:0] red_r,
  output logic [BYTE_W-1:0] green_r,
  output logic [BYTE_W-1:0] blue_r,
  output logic [BYTE_W-1:0] alpha_r,
  output logic              last_r
);

  logic [BYTE_W-1:0] b0, b1, b2, b3;
  logic [BYTE_W-1:0] red_nxt, green_nxt, blue_nxt, alpha_nxt;
  logic              load;
  logic              out_valid_nxt;

  assign b0 = stage.px[7:0];
  assign b1 = stage.px[15:8];
  assign b2 = stage.px[23:16];
  assign b3 = stage.px[31:24];

  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    alpha_nxt = '0;
    case (fmt)
      FMT_PAL8: begin
        if (stage.pal_hit) begin
          blue_nxt  = pal_word[7:0];
          green_nxt = pal_word[15:8];
          red_nxt   = pal_word[23:16];
          alpha_nxt = pal_word[31:24];
        end
      end
      FMT_RGB16: begin
        if (!(b0 == COLOR_KEY && b1 == COLOR_KEY)) begin
          red_nxt   = {b1[6:2], 3'b000};
          green_nxt = {b1[1:0], b0[7:5], 3'b000};
          blue_nxt  = {b0[4:0], 3'b000};
          alpha_nxt = OPAQUE;
        end
      end
      FMT_BGR24: begin
        if (!(b0 == COLOR_KEY && b1 == COLOR_KEY && b2 == COLOR_KEY)) begin
          red_nxt   = b2;
          green_nxt = b1;
          blue_nxt  = b0;
          alpha_nxt = OPAQUE;
        end
      end
      default: begin
        red_nxt   = b2;
        green_nxt = b1;
        blue_nxt  = b0;
        alpha_nxt = b3;
      end
    endcase
  end

  assign load          = stage.valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
      last_r  <= stage.last;
    end
  end

endmodule

// ----- hdl/bmp_pixel_to_rgba_unpacker_unit.sv -----
// ----------------------------------------------------------------------------
// bmp_pixel_to_rgba_unpacker_unit
// Unpacks the byte stream of a bottom-up BMP pixel array to RGBA8888 items.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_tready is high: a palette
// write or one raw byte of the pixel array, pad bytes included. A pixel
// result moves, after its last byte is taken, through the pixel stage,
// loaded together with the registered palette RAM read, and then the
// output register, loaded by the format conversion when that register is
// empty or being drained. The palette RAM takes one write and one read per
// cycle, and each item needs at most one of them. in_tready stays high as
// long as the output register is empty or being drained. Configuration
// writes take effect on the next cycle and are meant for idle periods only.
module bmp_pixel_to_rgba_unpacker_unit
  import bmpu_pkg::*;
#(
  parameter int MAX_WIDTH       = 4096,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  // input items
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,   // palette_index[7:0], palette_word[39:8],
                                        // data_byte[47:40]
  input  logic              in_tuser,   // req_type
  // result items
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // red[7:0], green[15:8], blue[23:16],
                                        // alpha[31:24]
  output logic              out_tlast   // last_pixel
);

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam int WCAP   = (MAX_WIDTH > (2 ** DIM_W) - 1) ? (2 ** DIM_W) - 1 : MAX_WIDTH;
  localparam logic [DIM_W-1:0] W_CAP = DIM_W'(WCAP);

  logic [1:0]       fmt_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [DIM_W-1:0] eff_width;
  logic [DIM_W-1:0] eff_height;

  logic              in_acc;
  logic              pix_acc;
  logic              pal_we;
  logic [BYTE_W-1:0] pal_idx;
  logic [PX_W-1:0]   pal_wdata;
  logic [BYTE_W-1:0] data_byte;
  logic              rd_en;
  logic [BYTE_W-1:0] rd_idx;
  logic [PX_W-1:0]   pal_rdata;
  logic              stage_ready;
  pix_stage_t        stage;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_BGR24;
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FORMAT: fmt_r    <= cfg_data[1:0];
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      eff_width = DIM_W'(1);
    end else if (width_r > W_CAP) begin
      eff_width = W_CAP;
    end else begin
      eff_width = width_r;
    end
    eff_height = (height_r == '0) ? DIM_W'(1) : height_r;
  end

  assign pal_idx   = in_tdata[7:0];
  assign pal_wdata = in_tdata[39:8];
  assign data_byte = in_tdata[47:40];

  // the pixel stage may load when it is empty or moves on this cycle
  assign stage_ready = !stage.valid || !out_tvalid || out_tready;
  assign in_tready   = stage_ready;
  assign in_acc      = in_tvalid && in_tready;
  assign pix_acc     = in_acc && (in_tuser == REQ_PIXEL);
  assign pal_we      = in_acc && (in_tuser == REQ_PALETTE) &&
                       ({1'b0, pal_idx} < 9'(PALETTE_ENTRIES));

  bmpu_ram #(
    .WIDTH (PX_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .we      (pal_we),
    .waddr   (pal_idx[PAL_AW-1:0]),
    .wdata   (pal_wdata),
    .re      (rd_en),
    .raddr   (rd_idx[PAL_AW-1:0]),
    .rdata_r (pal_rdata)
  );

  bmpu_gather #(
    .PAL_ENTRIES (PALETTE_ENTRIES)
  ) u_gather (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (pix_acc),
    .data_byte   (data_byte),
    .fmt         (fmt_r),
    .eff_width   (eff_width),
    .eff_height  (eff_height),
    .stage_ready (stage_ready),
    .rd_en       (rd_en),
    .rd_idx      (rd_idx),
    .stage_r     (stage)
  );

  bmpu_convert u_convert (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (stage),
    .pal_word    (pal_rdata),
    .fmt         (fmt_r),
    .out_ready   (out_tready),
    .out_valid_r (out_tvalid),
    .red_r       (out_tdata[7:0]),
    .green_r     (out_tdata[15:8]),
    .blue_r      (out_tdata[23:16]),
    .alpha_r     (out_tdata[31:24]),
    .last_r      (out_tlast)
  );

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low with empty output register");

  // a palette write never produces a pixel
  a_palette_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == REQ_PALETTE) |=> !stage.valid)
    else $error("palette write produced a pixel");

  // every palette read lands in the pixel stage next cycle
  a_read_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> stage.valid)
    else $error("palette read without a pixel stage load");

endmodule
